// ===== design/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros used by the id allocator design file.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("assertion failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("assertion failed");

`endif

// ===== design/bida_pkg.sv =====
// ---------------------------------------------------------------------------
// bida_pkg
// Field widths, opcodes and status codes of the id allocator.
// ---------------------------------------------------------------------------
package bida_pkg;

    // Port field widths.
    localparam int unsigned OPC_W  = 2;
    localparam int unsigned ID_W   = 11;
    localparam int unsigned BLK_W  = 32;
    localparam int unsigned STAT_W = 2;

    // Bitmap memory word layout.
    localparam int unsigned WORD_W = 32;
    localparam int unsigned BIT_W  = 5;

    typedef logic [OPC_W-1:0]  t_opcode;
    typedef logic [STAT_W-1:0] t_status;

    // Operation codes.
    localparam t_opcode OP_ALLOC   = 2'd0;
    localparam t_opcode OP_LOOKUP  = 2'd1;
    localparam t_opcode OP_RELEASE = 2'd2;

    // Status codes.
    localparam t_status ST_OK      = 2'd0;
    localparam t_status ST_NORES   = 2'd1;
    localparam t_status ST_INVALID = 2'd2;

endpackage

// ===== design/bida_ram.sv =====
// ---------------------------------------------------------------------------
// bida_ram
// Generic simple dual-port RAM: one write port, one read port with the
// read data registered.
// ---------------------------------------------------------------------------
module bida_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/bitmap_id_allocator_with_map_table.sv =====
// Allocate, lookup and release pass from the accepted input beat through a
// work state (S_ALC_WR, S_LKP or S_REL) and S_RESP to the registered result;
// an allocation on a full pool, a bad id or an unused opcode goes via S_BAD.
// A stalled response channel holds the block in S_RESP or S_BAD, and no new
// beat is taken until it is back in S_IDLE. After reset the block clears both
// memories and holds o_stall high meanwhile.
// ---------------------------------------------------------------------------
// bitmap_id_allocator_with_map_table
// Id allocator: allocation bitmap and id-to-block table held in RAM, a
// summary flag per bitmap word for the free search and a free-id counter.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module bitmap_id_allocator_with_map_table #(
    parameter int unsigned MAX_INODES = 1024
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // Request channel.
    input  logic                      i_valid,
    output logic                      o_stall,
    input  bida_pkg::t_opcode         i_opcode,
    input  logic [bida_pkg::ID_W-1:0]  i_inode_id,
    input  logic [bida_pkg::BLK_W-1:0] i_block_id,
    // Response channel.
    output logic                      o_valid,
    input  logic                      i_stall,
    output bida_pkg::t_status         o_status,
    output logic [bida_pkg::ID_W-1:0]  o_result_id,
    output logic [bida_pkg::BLK_W-1:0] o_mapped_block,
    output logic [bida_pkg::ID_W-1:0]  o_free_count
);

    import bida_pkg::*;

    localparam int unsigned IDX_W  = $clog2(MAX_INODES);
    localparam int unsigned CNT_W  = $clog2(MAX_INODES + 1);
    localparam int unsigned NW     = (MAX_INODES + WORD_W - 1) / WORD_W;
    localparam int unsigned WA_W   = (NW > 1) ? $clog2(NW) : 1;
    localparam int unsigned FULL_W = WA_W + BIT_W;

    typedef enum logic [6:0] {
        S_CLEAR  = 7'b0000001,
        S_IDLE   = 7'b0000010,
        S_ALC_WR = 7'b0000100,
        S_LKP    = 7'b0001000,
        S_REL    = 7'b0010000,
        S_RESP   = 7'b0100000,
        S_BAD    = 7'b1000000
    } t_state;

    t_state               r_state, n_state;
    logic [IDX_W-1:0]     r_clr;
    logic [NW-1:0]        r_sum;
    logic [CNT_W-1:0]     r_free;
    logic [WA_W-1:0]      r_word;
    logic [IDX_W-1:0]     r_idx;
    logic [BLK_W-1:0]     r_blk;
    t_status              r_res_status;
    logic [ID_W-1:0]      r_res_id;
    logic [BLK_W-1:0]     r_res_block;
    logic                 r_o_valid;
    t_status              r_o_status;
    logic [ID_W-1:0]      r_o_result_id;
    logic [BLK_W-1:0]     r_o_mapped_block;
    logic [ID_W-1:0]      r_o_free_count;

    logic                 w_accept;
    logic                 w_in_ok;
    logic [IDX_W-1:0]     w_in_idx;
    logic [WA_W-1:0]      w_in_word;
    logic [WA_W-1:0]      w_first_word;
    logic [BIT_W-1:0]     w_zero_bit;
    logic [IDX_W-1:0]     w_alc_idx;
    logic [CNT_W-1:0]     w_alc_num;
    logic [WORD_W-1:0]    w_alc_word;
    logic [BIT_W-1:0]     w_rel_bit;
    logic                 w_rel_used;
    logic [WORD_W-1:0]    w_rel_word;
    logic [WORD_W-1:0]    w_clr_word;
    logic                 w_clr_last;
    logic                 w_out_free;

    logic                 w_bm_we;
    logic [WA_W-1:0]      w_bm_waddr;
    logic [WORD_W-1:0]    w_bm_wdata;
    logic [WA_W-1:0]      w_bm_raddr;
    logic [WORD_W-1:0]    w_bm_rdata;
    logic                 w_tb_we;
    logic [IDX_W-1:0]     w_tb_waddr;
    logic [BLK_W-1:0]     w_tb_wdata;
    logic [BLK_W-1:0]     w_tb_rdata;

    // Input decode.
    assign w_accept  = i_valid && (r_state == S_IDLE);
    assign w_in_ok   = (i_inode_id != '0) && (32'(i_inode_id) <= 32'(MAX_INODES));
    assign w_in_idx  = IDX_W'(i_inode_id - ID_W'(1));
    assign w_in_word = WA_W'(w_in_idx >> BIT_W);
    assign w_out_free = !r_o_valid || !i_stall;

    // Lowest bitmap word that still holds a free id.
    always_comb begin
        w_first_word = '0;
        for (int i = NW - 1; i >= 0; i--) begin
            if (r_sum[i]) begin
                w_first_word = WA_W'(i);
            end
        end
    end

    // Lowest free bit inside the word read for an allocation.
    always_comb begin
        w_zero_bit = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (!w_bm_rdata[i]) begin
                w_zero_bit = BIT_W'(i);
            end
        end
    end

    assign w_alc_idx  = IDX_W'(FULL_W'({r_word, w_zero_bit}));
    assign w_alc_num  = CNT_W'(w_alc_idx) + CNT_W'(1);
    assign w_alc_word = w_bm_rdata | (WORD_W'(1) << w_zero_bit);

    // Release clears the bit of the id in its word.
    assign w_rel_bit  = BIT_W'(r_idx);
    assign w_rel_used = w_bm_rdata[w_rel_bit];
    assign w_rel_word = w_bm_rdata & ~(WORD_W'(1) << w_rel_bit);

    // Reset pattern of a bitmap word: bits past the pool are marked used.
    always_comb begin
        for (int b = 0; b < WORD_W; b++) begin
            w_clr_word[b] = ((32'(r_clr) << BIT_W) + 32'(b)) >= 32'(MAX_INODES);
        end
    end
    assign w_clr_last = (r_clr == IDX_W'(MAX_INODES - 1));

    // Memory port control.
    always_comb begin
        w_bm_we    = 1'b0;
        w_bm_waddr = r_word;
        w_bm_wdata = w_alc_word;
        w_tb_we    = 1'b0;
        w_tb_waddr = w_alc_idx;
        w_tb_wdata = r_blk;
        unique case (r_state)
            S_CLEAR: begin
                w_bm_we    = (32'(r_clr) < 32'(NW));
                w_bm_waddr = WA_W'(r_clr);
                w_bm_wdata = w_clr_word;
                w_tb_we    = 1'b1;
                w_tb_waddr = r_clr;
                w_tb_wdata = '0;
            end
            S_ALC_WR: begin
                w_bm_we = 1'b1;
                w_tb_we = 1'b1;
            end
            S_REL: begin
                w_bm_we    = 1'b1;
                w_bm_wdata = w_rel_word;
                w_tb_we    = 1'b1;
                w_tb_waddr = r_idx;
                w_tb_wdata = '0;
            end
            default: begin
                w_bm_we = 1'b0;
                w_tb_we = 1'b0;
            end
        endcase
    end

    assign w_bm_raddr = (i_opcode == OP_ALLOC) ? w_first_word : w_in_word;

    bida_ram #(
        .WIDTH (WORD_W),
        .DEPTH (NW)
    ) u_bitmap (
        .i_clk   (i_clk),
        .i_we    (w_bm_we),
        .i_waddr (w_bm_waddr),
        .i_wdata (w_bm_wdata),
        .i_raddr (w_bm_raddr),
        .o_rdata (w_bm_rdata)
    );

    bida_ram #(
        .WIDTH (BLK_W),
        .DEPTH (MAX_INODES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_tb_we),
        .i_waddr (w_tb_waddr),
        .i_wdata (w_tb_wdata),
        .i_raddr (w_in_idx),
        .o_rdata (w_tb_rdata)
    );

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        unique case (r_state) inside
            S_CLEAR: begin
                if (w_clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    if (i_opcode == OP_ALLOC) begin
                        n_state = (r_free != '0) ? S_ALC_WR : S_BAD;
                    end else if (i_opcode == OP_LOOKUP && w_in_ok) begin
                        n_state = S_LKP;
                    end else if (i_opcode == OP_RELEASE && w_in_ok) begin
                        n_state = S_REL;
                    end else begin
                        n_state = S_BAD;
                    end
                end
            end
            S_ALC_WR: n_state = S_RESP;
            S_LKP:    n_state = S_RESP;
            S_REL:    n_state = S_RESP;
            S_RESP, S_BAD: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_CLEAR;
        endcase
    end

    // Control state, counters and summary flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr     <= '0;
            r_sum     <= '1;
            r_free    <= CNT_W'(MAX_INODES);
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + IDX_W'(1);
            end
            if (r_state == S_ALC_WR) begin
                r_sum[r_word] <= (w_alc_word != '1);
                r_free        <= r_free - CNT_W'(1);
            end
            if (r_state == S_REL && w_rel_used) begin
                r_sum[r_word] <= 1'b1;
                r_free        <= r_free + CNT_W'(1);
            end
            if ((r_state == S_RESP || r_state == S_BAD) && w_out_free) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Request and result payload.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_word       <= w_bm_raddr;
            r_idx        <= w_in_idx;
            r_blk        <= i_block_id;
            r_res_id     <= '0;
            r_res_block  <= '0;
            if (i_opcode == OP_ALLOC) begin
                r_res_status <= (r_free != '0) ? ST_OK : ST_NORES;
            end else if (!((i_opcode == OP_LOOKUP || i_opcode == OP_RELEASE) && w_in_ok)) begin
                r_res_status <= ST_INVALID;
            end else begin
                r_res_status <= ST_OK;
            end
        end
        if (r_state == S_ALC_WR) begin
            r_res_id <= ID_W'(w_alc_num);
        end
        if (r_state == S_LKP) begin
            r_res_block <= w_tb_rdata;
        end
        if ((r_state == S_RESP || r_state == S_BAD) && w_out_free) begin
            r_o_status       <= r_res_status;
            r_o_result_id    <= r_res_id;
            r_o_mapped_block <= r_res_block;
            r_o_free_count   <= ID_W'(r_free);
        end
    end

    assign o_stall        = (r_state != S_IDLE);
    assign o_valid        = r_o_valid;
    assign o_status       = r_o_status;
    assign o_result_id    = r_o_result_id;
    assign o_mapped_block = r_o_mapped_block;
    assign o_free_count   = r_o_free_count;

    // An empty pool must leave no word flagged as holding a free id.
    `ASSERT_IMPL(a_sum_empty, (r_state == S_IDLE) && (r_free == '0), r_sum == '0)
    // The word read for an allocation always holds a free bit.
    `ASSERT_IMPL(a_alc_word_free, r_state == S_ALC_WR, w_bm_rdata != '1)
    // A finished result is shown on the next cycle.
    `ASSERT_NEXT(a_resp_shown, (r_state == S_RESP || r_state == S_BAD) && w_out_free, o_valid)

endmodule
